// ===== rtl/ksc_pkg.sv =====
// ----------------------------------------------------------------------------
// ksc_pkg
// Shared types and constants for the keyword substitution cipher: command
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ksc_pkg;

   // alphabet size and index width
   localparam int LETTERS   = 26;
   localparam int IDX_W     = $clog2(LETTERS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);

   // ascii bounds of the lowercase range
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;

   // request command codes
   typedef enum logic [1:0] {
      CMD_KEY  = 2'd0,
      CMD_SEAL = 2'd1,
      CMD_TEXT = 2'd2
   } cmd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_SEAL_KEY  = 2'd1,
      ST_SEAL_FILL = 2'd2
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept_key;
      logic accept_text;
      logic seal_start;
      logic key_step;
      logic fill_step;
      logic walk_restart;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pend_empty;
      logic key_last;
      logic fill_last;
   } dp_status_type;

endpackage

// ===== rtl/ksc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksc_ctrl
// Controller: request/response handshakes, output valid flag and the seal
// sequencer that walks the keyword list and then the unused letters.
// ----------------------------------------------------------------------------
module ksc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ksc_pkg::dp_status_type status,
   output ksc_pkg::ctrl_cmd_type  ctrl
);

   ksc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic accept;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ksc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // handshake
   assign slot_free = rsp_ready || !rsp_valid_ff;
   assign req_ready = (state_ff == ksc_pkg::ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ksc_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  ksc_pkg::CMD_KEY:  ctrl.accept_key  = 1'b1;
                  ksc_pkg::CMD_TEXT: ctrl.accept_text = 1'b1;
                  ksc_pkg::CMD_SEAL: begin
                     ctrl.seal_start = 1'b1;
                     state_in = status.pend_empty ? ksc_pkg::ST_SEAL_FILL
                                                  : ksc_pkg::ST_SEAL_KEY;
                  end
                  default: ;
               endcase
            end
         end
         ksc_pkg::ST_SEAL_KEY: begin
            ctrl.key_step = 1'b1;
            if (status.key_last) begin
               ctrl.walk_restart = 1'b1;
               state_in = ksc_pkg::ST_SEAL_FILL;
            end
         end
         ksc_pkg::ST_SEAL_FILL: begin
            ctrl.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ksc_pkg::ST_IDLE;
            end
         end
         default: state_in = ksc_pkg::ST_IDLE;
      endcase
   end

   // result held until transferred
   assign rsp_valid_in = ctrl.accept_text || (rsp_valid_ff && !rsp_ready);

endmodule

// ===== rtl/ksc_datapath.sv =====
// ----------------------------------------------------------------------------
// ksc_datapath
// Datapath: direction register, pending keyword list, forward and inverse
// substitution tables, seal walk counters and the result register.
// ----------------------------------------------------------------------------
module ksc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  logic [7:0]             req_data,
   input  logic                   req_key_start,
   input  ksc_pkg::ctrl_cmd_type  ctrl,
   output ksc_pkg::dp_status_type status,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_substituted
);

   localparam int IW = ksc_pkg::IDX_W;
   localparam int NL = ksc_pkg::LETTERS;

   logic                direction_ff;
   logic [IW-1:0]       pend_ff [NL];
   logic [NL-1:0]       seen_ff, seen_in;
   logic [IW-1:0]       count_ff, count_in;
   logic [IW-1:0]       walk_ff, walk_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [IW-1:0]       fwd_ff [NL];
   logic [IW-1:0]       inv_ff [NL];
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                subst_ff;

   logic                is_lower;
   logic [7:0]          offset;
   logic [IW-1:0]       letter;
   logic [NL-1:0]       base_seen;
   logic [IW-1:0]       base_count;
   logic                add_letter;
   logic                fill_free;
   logic                tbl_we;
   logic [IW-1:0]       tbl_val;
   logic [IW-1:0]       lookup;

   // decode of the request byte
   assign is_lower = (req_data >= ksc_pkg::ASCII_LOWER_A) &&
                     (req_data <= ksc_pkg::ASCII_LOWER_Z);
   assign offset   = req_data - ksc_pkg::ASCII_LOWER_A;
   assign letter   = offset[IW-1:0];

   // keyword letter: optional restart, then drop repeats and overflow
   always_comb begin
      base_seen  = req_key_start ? '0 : seen_ff;
      base_count = req_key_start ? '0 : count_ff;
      add_letter = is_lower && !base_seen[letter] && (base_count < IW'(NL));
      seen_in    = base_seen | (add_letter ? (NL'(1) << letter) : '0);
      count_in   = base_count + IW'(add_letter);
   end

   // configuration, list bookkeeping and walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         seen_ff      <= '0;
         count_ff     <= '0;
         walk_ff      <= '0;
         pos_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
         end
         if (ctrl.accept_key) begin
            seen_ff  <= seen_in;
            count_ff <= count_in;
         end
         walk_ff <= walk_in;
         pos_ff  <= pos_in;
      end
   end

   // pending letter store
   always_ff @(posedge clock) begin
      if (ctrl.accept_key && add_letter) begin
         pend_ff[base_count] <= letter;
      end
   end

   // seal walk: keyword letters first, then unused letters in order
   assign fill_free = !seen_ff[walk_ff];
   assign tbl_we    = ctrl.key_step || (ctrl.fill_step && fill_free);
   assign tbl_val   = ctrl.key_step ? pend_ff[walk_ff] : walk_ff;

   always_comb begin
      walk_in = walk_ff;
      pos_in  = pos_ff;
      if (ctrl.seal_start || ctrl.walk_restart) begin
         walk_in = '0;
      end else if (ctrl.key_step || ctrl.fill_step) begin
         walk_in = walk_ff + IW'(1);
      end
      if (ctrl.seal_start) begin
         pos_in = '0;
      end else if (tbl_we) begin
         pos_in = pos_ff + IW'(1);
      end
   end

   // status back to the controller
   always_comb begin
      status.pend_empty = (count_ff == '0);
      status.key_last   = ((walk_ff + IW'(1)) == count_ff);
      status.fill_last  = (walk_ff == ksc_pkg::LAST_IDX);
   end

   // substitution tables, identity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            fwd_ff[i] <= IW'(i);
            inv_ff[i] <= IW'(i);
         end
      end else if (tbl_we) begin
         fwd_ff[pos_ff]  <= tbl_val;
         inv_ff[tbl_val] <= pos_ff;
      end
   end

   // text lookup and result register
   assign lookup      = direction_ff ? inv_ff[letter] : fwd_ff[letter];
   assign out_byte_in = is_lower ? (ksc_pkg::ASCII_LOWER_A + 8'(lookup)) : req_data;

   always_ff @(posedge clock) begin
      if (ctrl.accept_text) begin
         out_byte_ff <= out_byte_in;
         subst_ff    <= is_lower;
      end
   end

   assign rsp_out_byte    = out_byte_ff;
   assign rsp_substituted = subst_ff;

endmodule

// ===== rtl/keyword_substitution_cipher.sv =====
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword substitution cipher: keyword letters collect in a pending list, a
// seal builds the cipher alphabet and its inverse, text bytes a to z are
// substituted forward or inverse, other bytes pass through.
//
//   channel   ports                               direction
//   request   req_valid/req_ready, req_cmd,       in
//             req_data, req_key_start
//   response  rsp_valid/rsp_ready, rsp_out_byte,  out
//             rsp_substituted
//   control   csr_wr_en, csr_wr_data              in, write only
//
// Keyword and text transfers can follow back to back; a text result appears
// in the output register the cycle after its transfer.
// A seal keeps req_ready low while the sequencer writes a table entry pair
// for each pending keyword letter and then for each unused letter.
// Reset sets both tables to the identity at once; there is no clearing pass.
// A result waiting on rsp_ready holds req_ready low for every command.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_data,
   input  logic       req_key_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_substituted
);

   ksc_pkg::ctrl_cmd_type  ctrl;
   ksc_pkg::dp_status_type status;

   // sequencer and handshakes
   ksc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // tables and result register
   ksc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_data        (req_data),
      .req_key_start   (req_key_start),
      .ctrl            (ctrl),
      .status          (status),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_substituted (rsp_substituted)
   );

endmodule

// ===== rtl/ksc_checker.sv =====
// ----------------------------------------------------------------------------
// ksc_checker
// Port level checks for the keyword substitution cipher, bound to the top.
// ----------------------------------------------------------------------------
module ksc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_cmd,
   input logic [7:0] req_data,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_substituted
);

   logic req_xfer;
   logic req_lower;
   logic rsp_lower;

   assign req_xfer  = req_valid && req_ready;
   assign req_lower = (req_data >= ksc_pkg::ASCII_LOWER_A) &&
                      (req_data <= ksc_pkg::ASCII_LOWER_Z);
   assign rsp_lower = (rsp_out_byte >= ksc_pkg::ASCII_LOWER_A) &&
                      (rsp_out_byte <= ksc_pkg::ASCII_LOWER_Z);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_substituted))
      else $error("stalled result changed");

   // text transfer gives a result next cycle, flagged by letter class
   a_text_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_cmd == ksc_pkg::CMD_TEXT)
         |=> rsp_valid && (rsp_substituted == $past(req_lower)))
      else $error("text transfer without matching result");

   // other commands make no result
   a_no_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_cmd != ksc_pkg::CMD_TEXT) && !rsp_valid |=> !rsp_valid)
      else $error("result from a non-text command");

   // substituted letters stay letters
   a_subst_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_substituted |-> rsp_lower)
      else $error("substituted byte outside a to z");

   // passed bytes are never letters
   a_pass_other: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_substituted |-> !rsp_lower)
      else $error("letter passed through unsubstituted");

endmodule

bind keyword_substitution_cipher ksc_checker u_checker (.*);
